// File: src/crm_pkg.sv
`timescale 1ns / 1ps

package crm_pkg;

  localparam int MaxRecords  = 128;
  localparam int RecordBytes = 64;

  localparam int PosW = (RecordBytes > 1) ? $clog2(RecordBytes) : 1;
  localparam int CntW = $clog2(MaxRecords + 1);

  typedef enum logic [1:0] {
    KindLoad  = 2'd0,
    KindQuery = 2'd1,
    KindClear = 2'd2,
    KindBadOp = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusBadOp = 2'd2
  } status_e;

  // one item as it travels down the row of record cells
  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [7:0]      data;
    logic [PosW-1:0] lpos;
    logic [PosW-1:0] qpos;
    logic [CntW-1:0] cnt_before;
    logic [CntW-1:0] cnt_after;
    logic            last;
    logic            match;
    status_e         status;
  } crm_tok_t;

endpackage

// File: src/crm_ctrl.sv
`timescale 1ns / 1ps

module crm_ctrl
  import crm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  logic     accept_i,
  input  kind_e    kind_i,
  input  logic [7:0] data_byte_i,
  output crm_tok_t tok_o
);

  logic [CntW-1:0] count_q, count_d;
  logic [PosW-1:0] lpos_q, lpos_d;
  logic [PosW-1:0] qpos_q, qpos_d;
  crm_tok_t        tok_q, tok_d;
  logic            last_q_byte;
  status_e         status;

  assign last_q_byte = (qpos_q == PosW'(RecordBytes - 1));

  always_comb begin
    count_d = count_q;
    lpos_d  = lpos_q;
    qpos_d  = qpos_q;
    status  = StatusOk;
    unique case (kind_i)
      KindLoad: begin
        if (count_q >= CntW'(MaxRecords)) begin
          status = StatusFull;
        end else if (lpos_q == PosW'(RecordBytes - 1)) begin
          lpos_d  = '0;
          count_d = CntW'(count_q + 1'b1);
        end else begin
          lpos_d = PosW'(lpos_q + 1'b1);
        end
      end
      KindQuery: begin
        qpos_d = last_q_byte ? '0 : PosW'(qpos_q + 1'b1);
      end
      KindClear: begin
        count_d = '0;
        lpos_d  = '0;
        qpos_d  = '0;
      end
      KindBadOp: begin
        status = StatusBadOp;
      end
      default: begin
        status = StatusBadOp;
      end
    endcase
  end

  always_comb begin
    tok_d            = '0;
    tok_d.valid      = accept_i;
    tok_d.kind       = kind_i;
    tok_d.data       = data_byte_i;
    tok_d.lpos       = lpos_q;
    tok_d.qpos       = qpos_q;
    tok_d.cnt_before = count_q;
    tok_d.cnt_after  = count_d;
    tok_d.last       = (kind_i == KindQuery) && last_q_byte;
    tok_d.match      = 1'b0;
    tok_d.status     = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lpos_q  <= '0;
      qpos_q  <= '0;
      tok_q   <= '0;
    end else if (advance_i) begin
      if (accept_i) begin
        count_q <= count_d;
        lpos_q  <= lpos_d;
        qpos_q  <= qpos_d;
      end
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxRecords))
    else $error("record count above table size");

  a_load_pos_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lpos_q != '0) |-> (count_q < CntW'(MaxRecords)))
    else $error("partial record while table full");

  a_last_is_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_q.valid && tok_q.last) |-> (tok_q.kind == KindQuery))
    else $error("record end flagged on a non-query word");

endmodule

// File: src/crm_cell.sv
`timescale 1ns / 1ps

module crm_cell
  import crm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [CntW-1:0] cell_idx_i,
  input  crm_tok_t        tok_i,
  output crm_tok_t        tok_o
);

  logic [7:0] rec_mem [RecordBytes];
  logic [7:0] rd_q;
  crm_tok_t   tok_a_q;
  crm_tok_t   tok_b_q, tok_b_d;
  logic       flag_q, flag_d;
  logic       wr_en;
  logic       slot_valid;
  logic       eq_flag;

  assign wr_en = advance_i && tok_i.valid && (tok_i.kind == KindLoad) &&
                 (tok_i.status == StatusOk) && (tok_i.cnt_before == cell_idx_i);

  // record bytes, read one stage ahead of the compare
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[tok_i.lpos] <= tok_i.data;
    end
    if (advance_i) begin
      rd_q <= rec_mem[tok_i.qpos];
    end
  end

  assign slot_valid = (cell_idx_i < tok_a_q.cnt_before);

  always_comb begin
    flag_d  = flag_q;
    tok_b_d = tok_a_q;
    eq_flag = ((tok_a_q.qpos == '0) ? 1'b1 : flag_q) && (rd_q == tok_a_q.data);
    if (tok_a_q.valid) begin
      case (tok_a_q.kind)
        KindQuery: begin
          flag_d = slot_valid && eq_flag;
          if (tok_a_q.last) begin
            tok_b_d.match = tok_a_q.match | flag_d;
          end
        end
        KindClear: begin
          flag_d = 1'b1;
        end
        default: begin
          flag_d = flag_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
      flag_q  <= 1'b1;
    end else if (advance_i) begin
      tok_a_q <= tok_i;
      tok_b_q <= tok_b_d;
      flag_q  <= flag_d;
    end
  end

  assign tok_o = tok_b_q;

  a_match_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_b_q.valid && !tok_b_q.last) |-> !tok_b_q.match)
    else $error("match raised before the end of a query record");

  a_clear_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && tok_a_q.valid && (tok_a_q.kind == KindClear)) |=> flag_q)
    else $error("equal flag not restored by clear");

endmodule

// File: src/contact_record_matcher.sv
`timescale 1ns / 1ps

// exact-match store of 64-byte contact records, one byte per word
// input: s_axis_tuser carries the operation (load, query, clear, invalid),
//   s_axis_tdata the record byte; a word is taken when tvalid and tready are high
// output: one word per input word, in order; tuser flags a finished query,
//   tdata holds matched, the valid record count after the word and status
// every record slot is a cell in a row of MaxRecords cells; each cell keeps its
//   own 64-byte record memory and equal flag, and a word passes each cell through
//   a memory read stage, then a compare stage, carrying the running match bit along
// one word per cycle is sustained while the receiver takes the output words
// when the receiver stalls with a word waiting at the output, the whole row
//   holds and s_axis_tready drops until that word is taken
// reset empties the table, clears all positions and the row; record memory
//   keeps no reset and its read data is only used for fully loaded records

module contact_record_matcher
  import crm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] matched, [8:1] contact_count, [10:9] status
  output logic [0:0]  m_axis_tuser   // [0] match_valid
);

  crm_tok_t   tok_chain [MaxRecords + 1];
  crm_tok_t   tok_out;
  logic       advance;
  logic       accept;
  logic [7:0] count_byte;

  assign tok_out       = tok_chain[MaxRecords];
  assign advance       = !tok_out.valid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  crm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .accept_i    (accept),
    .kind_i      (kind_e'(s_axis_tuser)),
    .data_byte_i (s_axis_tdata),
    .tok_o       (tok_chain[0])
  );

  for (genvar i = 0; i < MaxRecords; i++) begin : g_cell
    crm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .cell_idx_i (CntW'(i)),
      .tok_i      (tok_chain[i]),
      .tok_o      (tok_chain[i + 1])
    );
  end

  assign count_byte    = 8'(tok_out.cnt_after);
  assign m_axis_tvalid = tok_out.valid;
  assign m_axis_tuser  = tok_out.last;
  assign m_axis_tdata  = {5'b0, tok_out.status, count_byte, tok_out.match};

  a_matched_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> !m_axis_tdata[0])
    else $error("matched set on a word that ends no query");

endmodule
